>>> design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [7:0]  DEV_ADDR_RESET  = 8'hE0;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_WRITE,
    KIND_READ,
    KIND_TICK
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [1:0] nack_count;
  } result_t;

  typedef enum logic [13:0] {
    PH_IDLE       = 14'b00000000000001,
    PH_START_HI   = 14'b00000000000010,
    PH_START_FALL = 14'b00000000000100,
    PH_TX_LOW     = 14'b00000000001000,
    PH_TX_HIGH    = 14'b00000000010000,
    PH_ACK_LOW    = 14'b00000000100000,
    PH_ACK_HIGH   = 14'b00000001000000,
    PH_RX_LOW     = 14'b00000010000000,
    PH_RX_HIGH    = 14'b00000100000000,
    PH_NAK_LOW    = 14'b00001000000000,
    PH_NAK_HIGH   = 14'b00010000000000,
    PH_STOP_LOW   = 14'b00100000000000,
    PH_STOP_RISE  = 14'b01000000000000,
    PH_STOP_END   = 14'b10000000000000
  } phase_t;

endpackage

>>> design/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input beats, classifies the function code and queues the items.
// ----------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  output logic       q_valid,
  input  logic       q_ready,
  output item_t      q_item
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  item_t            q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  item_t            in_item;
  logic             push;
  logic             pop;

  always_comb begin
    in_item.reg_addr   = reg_addr;
    in_item.write_data = write_data;
    in_item.sda_in     = sda_in;
    unique case (func)
      FUNC_WRITE: in_item.kind = KIND_WRITE;
      FUNC_READ:  in_item.kind = KIND_READ;
      FUNC_TICK:  in_item.kind = KIND_TICK;
      default:    in_item.kind = KIND_NOP;
    endcase
  end

  assign in_ready = (count != CNT_FULL);
  assign q_valid  = (count != '0);
  assign q_item   = q_mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// Bus phase sequencer: one queued item per cycle while the output is not
// stalled, result held in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cm_back
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       q_valid,
  output logic       q_ready,
  input  item_t      q_item,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    result
);

  logic [7:0] dev_addr;
  phase_t     phase, phase_next;
  logic [2:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] byte_stage, byte_stage_next;
  logic       is_read, is_read_next;
  logic [7:0] held_reg_addr, held_reg_addr_next;
  logic [7:0] held_write_data, held_write_data_next;
  logic [1:0] nack_total, nack_total_next;
  logic [7:0] received_byte, received_byte_next;
  logic       scl_drive, scl_drive_next;
  logic       sda_drive, sda_drive_next;
  logic       done_next;
  logic [2:0] stage_inc;
  logic       fire;

  assign q_ready   = !out_valid || out_ready;
  assign fire      = q_valid && q_ready;
  assign stage_inc = byte_stage + 3'd1;

  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    shift_byte_next      = shift_byte;
    byte_stage_next      = byte_stage;
    is_read_next         = is_read;
    held_reg_addr_next   = held_reg_addr;
    held_write_data_next = held_write_data;
    nack_total_next      = nack_total;
    received_byte_next   = received_byte;
    scl_drive_next       = scl_drive;
    sda_drive_next       = sda_drive;
    done_next            = 1'b0;

    if (q_item.kind == KIND_WRITE || q_item.kind == KIND_READ) begin
      if (phase == PH_IDLE) begin
        is_read_next         = (q_item.kind == KIND_READ);
        held_reg_addr_next   = q_item.reg_addr;
        held_write_data_next = q_item.write_data;
        nack_total_next      = 2'd0;
        byte_stage_next      = 3'd0;
        bit_count_next       = 3'd0;
        phase_next           = PH_START_HI;
      end
    end else if (q_item.kind == KIND_TICK) begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_START_HI: begin
          scl_drive_next = 1'b1;
          sda_drive_next = 1'b1;
          phase_next     = PH_START_FALL;
        end
        PH_START_FALL: begin
          scl_drive_next  = 1'b1;
          sda_drive_next  = 1'b0;
          shift_byte_next = (byte_stage == 3'd0) ? dev_addr : dev_addr + 8'd1;
          bit_count_next  = 3'd0;
          phase_next      = PH_TX_LOW;
        end
        PH_TX_LOW: begin
          scl_drive_next = 1'b0;
          sda_drive_next = shift_byte[7];
          phase_next     = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          scl_drive_next  = 1'b1;
          sda_drive_next  = shift_byte[7];
          shift_byte_next = {shift_byte[6:0], 1'b0};
          if (bit_count == 3'd7) begin
            bit_count_next = 3'd0;
            phase_next     = PH_ACK_LOW;
          end else begin
            bit_count_next = bit_count + 3'd1;
            phase_next     = PH_TX_LOW;
          end
        end
        PH_ACK_LOW: begin
          scl_drive_next = 1'b0;
          sda_drive_next = 1'b1;
          phase_next     = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          scl_drive_next  = 1'b1;
          sda_drive_next  = 1'b1;
          if (q_item.sda_in && nack_total != 2'd3) begin
            nack_total_next = nack_total + 2'd1;
          end
          byte_stage_next = stage_inc;
          if (stage_inc == 3'd1) begin
            shift_byte_next = held_reg_addr;
            bit_count_next  = 3'd0;
            phase_next      = PH_TX_LOW;
          end else if (!is_read) begin
            if (stage_inc == 3'd2) begin
              shift_byte_next = held_write_data;
              bit_count_next  = 3'd0;
              phase_next      = PH_TX_LOW;
            end else begin
              phase_next = PH_STOP_LOW;
            end
          end else begin
            if (stage_inc == 3'd2) begin
              phase_next = PH_STOP_LOW;
            end else begin
              shift_byte_next = 8'd0;
              bit_count_next  = 3'd0;
              phase_next      = PH_RX_LOW;
            end
          end
        end
        PH_RX_LOW: begin
          scl_drive_next = 1'b0;
          sda_drive_next = 1'b1;
          phase_next     = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          scl_drive_next = 1'b1;
          sda_drive_next = 1'b1;
          if (q_item.sda_in) begin
            shift_byte_next[3'd7 - bit_count] = 1'b1;
          end
          if (bit_count == 3'd7) begin
            bit_count_next     = 3'd0;
            received_byte_next = shift_byte_next;
            phase_next         = PH_NAK_LOW;
          end else begin
            bit_count_next = bit_count + 3'd1;
            phase_next     = PH_RX_LOW;
          end
        end
        PH_NAK_LOW: begin
          scl_drive_next = 1'b0;
          sda_drive_next = 1'b1;
          phase_next     = PH_NAK_HIGH;
        end
        PH_NAK_HIGH: begin
          scl_drive_next  = 1'b1;
          sda_drive_next  = 1'b1;
          byte_stage_next = 3'd5;
          phase_next      = PH_STOP_LOW;
        end
        PH_STOP_LOW: begin
          scl_drive_next = 1'b0;
          sda_drive_next = 1'b0;
          phase_next     = PH_STOP_RISE;
        end
        PH_STOP_RISE: begin
          scl_drive_next = 1'b1;
          sda_drive_next = 1'b0;
          phase_next     = PH_STOP_END;
        end
        PH_STOP_END: begin
          scl_drive_next = 1'b1;
          sda_drive_next = 1'b1;
          if (is_read && byte_stage == 3'd2) begin
            // stop, then a new start for the read address
            byte_stage_next = 3'd3;
            phase_next      = PH_START_HI;
          end else begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEV_ADDR_RESET;
    end else if (cfg_we) begin
      dev_addr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= 3'd0;
      shift_byte      <= 8'd0;
      byte_stage      <= 3'd0;
      is_read         <= 1'b0;
      held_reg_addr   <= 8'd0;
      held_write_data <= 8'd0;
      nack_total      <= 2'd0;
      received_byte   <= 8'd0;
      scl_drive       <= 1'b1;
      sda_drive       <= 1'b1;
    end else if (fire) begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      shift_byte      <= shift_byte_next;
      byte_stage      <= byte_stage_next;
      is_read         <= is_read_next;
      held_reg_addr   <= held_reg_addr_next;
      held_write_data <= held_write_data_next;
      nack_total      <= nack_total_next;
      received_byte   <= received_byte_next;
      scl_drive       <= scl_drive_next;
      sda_drive       <= sda_drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.scl_level  <= scl_drive_next;
      result.sda_level  <= sda_drive_next;
      result.busy_res   <= (phase_next != PH_IDLE);
      result.done_res   <= done_next;
      result.read_data  <= received_byte_next;
      result.nack_count <= nack_total_next;
    end
  end

endmodule

>>> design/i2c_master_register_access_core.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access_core
// I2C master for single-byte register writes and reads, one bus phase a beat.
// ----------------------------------------------------------------------------
// Input beats carry a function code: write command, read command or a phase
// tick from an external bit-rate divider. A command latches the register
// address and write data; each tick runs one bus phase (START, address bits,
// ACK slots, data, STOP) and sda_in is sampled in ACK and receive phases.
// Every input beat gives exactly one result beat with the SCL/SDA drive
// levels, busy and done flags, the last byte read and the missing-ACK count.
// The user must write the device address register through cfg_we/cfg_wdata
// only while idle; the block itself does not enforce this. An accepted input
// beat passes through the input queue, then through the phase sequencer into
// the output register. Throughput is one beat per cycle while out_ready is
// high. When out_ready is low the result register holds and the input queue
// keeps taking beats until it is full; in_ready then drops.
// Reset empties the queue, clears the output valid flag, returns the sequencer
// to idle with both lines released and loads device address 0xE0.
// ----------------------------------------------------------------------------
module i2c_master_register_access_core
  import i2cm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_level,
  output logic       sda_level,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data,
  output logic [1:0] nack_count
);

  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  result_t result;

  i2cm_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .reg_addr  (reg_addr),
    .write_data(write_data),
    .sda_in    (sda_in),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  i2cm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result   (result)
  );

  assign scl_level  = result.scl_level;
  assign sda_level  = result.sda_level;
  assign busy_res   = result.busy_res;
  assign done_res   = result.done_res;
  assign read_data  = result.read_data;
  assign nack_count = result.nack_count;

endmodule

>>> design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result channel of the I2C register access master.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_data,
  input logic [1:0] nack_count
);

  // stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({scl_level, sda_level, busy_res, done_res,
                                         read_data, nack_count}))
    else $error("result payload changed while stalled");

  // lines are released whenever the master is idle
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> scl_level && sda_level)
    else $error("bus line held low while idle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done flagged while still busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind i2c_master_register_access_core i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .scl_level (scl_level),
  .sda_level (sda_level),
  .busy_res  (busy_res),
  .done_res  (done_res),
  .read_data (read_data),
  .nack_count(nack_count)
);
